@@ src/symbol_hash_table_quadratic_probe_assert.svh @@
// ----------------------------------------------------------------------------
// Symbol hash table assertion macros
// Clocked, reset-qualified assertion helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH
`define SYMBOL_HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define SHTQP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SHTQP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ src/shtqp_pkg.sv @@
// ----------------------------------------------------------------------------
// Symbol hash table package
// Transaction payload types, status and state codes, fixed field widths.
// ----------------------------------------------------------------------------
package shtqp_pkg;

    localparam int CHAR_BITS = 7;
    localparam int HASH_BITS = 16;
    localparam int NAME_BITS = 56;
    localparam int FLAG_BITS = 3;
    localparam int SLOT_BITS = 10;

    // Flag bit positions
    localparam int FLAG_REL = 0;
    localparam int FLAG_ENT = 1;
    localparam int FLAG_EXT = 2;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_ABSENT   = 2'd1,
        STATUS_INSERTED = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_REM,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                 cmd;
        logic [NAME_BITS-1:0] sym_name;
        logic                 entry_req;
        logic                 external_req;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_BITS-1:0] slot_index;
        logic [FLAG_BITS-1:0] slot_flags;
    } rsp_t;

endpackage

@@ src/shtqp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module shtqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/symbol_hash_table_quadratic_probe.sv @@
// ----------------------------------------------------------------------------
// Symbol hash table with quadratic probing
// Open-addressing symbol table: lookup or add of fixed-length names.
// ----------------------------------------------------------------------------
// One request transaction carries a command (lookup or add), a name of
// NAME_CHARS 7-bit characters in the low bits of sym_name (first character
// highest) and the entry/external flag requests; one response transaction
// returns found, absent, inserted or full with the slot and its flags. Names
// and flags live in one RAM of TABLE_SLOTS entries. After reset a clearing
// pass writes every entry to zero, one entry per cycle, with req_stall
// high. Items are handled one at a time: S_IDLE accepts, S_HASH folds the
// name into a 16-bit hash, S_MOD and S_REM reduce the hash modulo
// TABLE_SLOTS (a reciprocal multiply for the quotient, then a subtract with
// one correction step), each probe is a RAM read (S_READ) then a compare
// and write back (S_CHECK), and S_DONE loads the response register. A
// full table counts one more probe for the final read that fetches the
// flags of the wrapped slot; with 1024 slots that is 512 probes. The RAM
// read port paces the probe loop. A stalled response holds the block in
// S_DONE until the output register frees up. A request may be accepted
// while the previous response still waits in the output register.
module symbol_hash_table_quadratic_probe #(
    parameter int TABLE_SLOTS = 1024,
    parameter int NAME_CHARS  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  shtqp_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output shtqp_pkg::rsp_t   rsp
);

    localparam int AW    = $clog2(TABLE_SLOTS);
    localparam int NW    = NAME_CHARS * shtqp_pkg::CHAR_BITS;
    localparam int FW    = shtqp_pkg::FLAG_BITS;
    localparam int DW    = NW + FW;
    localparam int HW    = shtqp_pkg::HASH_BITS;
    // Reciprocal of the table size scaled by 2^16; the quotient estimate
    // is never high and at most one low
    localparam int RECIP = (1 << HW) / TABLE_SLOTS;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int QW    = HW - AW + 1;

    // Control registers
    shtqp_pkg::state_t state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath registers
    logic                cmd_reg, cmd_next;
    logic [NW-1:0]       name_reg, name_next;
    logic [FW-1:0]       new_flags_reg, new_flags_next;
    logic [HW-1:0]       rem_reg, rem_next;
    logic [QW-1:0]       quot_reg, quot_next;
    logic [AW-1:0]       h_reg, h_next;
    logic [AW:0]         d_reg, d_next;
    logic                full_reg, full_next;
    shtqp_pkg::status_t  res_status_reg, res_status_next;
    logic [FW-1:0]       res_flags_reg, res_flags_next;
    shtqp_pkg::rsp_t     out_data_reg, out_data_next;

    // RAM port signals
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [DW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [DW-1:0] ram_rd_data;

    // Derived values
    logic [HW-1:0]    hash_val;
    logic [HW+RW-1:0] quot_prod;
    logic [HW-1:0]    rem_part;
    logic [AW-1:0]    rem_fin;
    logic [AW:0]      probe_sum;
    logic [AW-1:0]    h_wrap;
    logic [AW:0]      d_inc;
    logic [NW-1:0]    rd_name;
    logic [FW-1:0]    rd_flags;
    logic             slot_empty;
    logic             slot_match;
    logic [31:0]      h_wide;

    shtqp_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Fold character pairs into the 16-bit hash; an odd last character
    // takes no part.
    always_comb
    begin
        logic [HW-1:0] acc;
        acc = '0;
        for (int i = 0; i < NAME_CHARS / 2; i++)
        begin
            acc = acc
                + (HW'(name_reg[shtqp_pkg::CHAR_BITS * (NAME_CHARS - 1 - 2 * i)
                                +: shtqp_pkg::CHAR_BITS]) << 7)
                + (HW'(name_reg[shtqp_pkg::CHAR_BITS * (NAME_CHARS - 2 - 2 * i)
                                +: shtqp_pkg::CHAR_BITS]) << 1);
        end
        hash_val = acc;
    end

    // Modulo by reciprocal: estimate the quotient, subtract its multiple,
    // then take off one more table size if the estimate was one low.
    assign quot_prod = (HW + RW)'(rem_reg) * (HW + RW)'(RECIP);
    assign rem_part  = rem_reg - HW'(quot_reg) * HW'(TABLE_SLOTS);
    assign rem_fin   = (rem_part >= HW'(TABLE_SLOTS))
                     ? AW'(rem_part - HW'(TABLE_SLOTS))
                     : rem_part[AW-1:0];

    // Next probe position; h stays below TABLE_SLOTS, d reaches at most TABLE_SLOTS.
    assign probe_sum = {1'b0, h_reg} + d_reg;
    assign h_wrap    = (probe_sum >= (AW + 1)'(TABLE_SLOTS))
                     ? AW'(probe_sum - (AW + 1)'(TABLE_SLOTS))
                     : probe_sum[AW-1:0];
    assign d_inc     = d_reg + (AW + 1)'(2);

    assign rd_name    = ram_rd_data[DW-1:FW];
    assign rd_flags   = ram_rd_data[FW-1:0];
    assign slot_empty = (rd_name[NW-1 -: shtqp_pkg::CHAR_BITS] == '0);
    assign slot_match = (rd_name == name_reg);

    assign h_wide = 32'(h_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg & rsp_stall;
        out_data_next   = out_data_reg;
        cmd_next        = cmd_reg;
        name_next       = name_reg;
        new_flags_next  = new_flags_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        h_next          = h_reg;
        d_next          = d_reg;
        full_next       = full_reg;
        res_status_next = res_status_reg;
        res_flags_next  = res_flags_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = h_reg;
        ram_wr_data     = {name_reg, new_flags_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = h_reg;
        req_stall       = 1'b1;

        unique case (state_reg)
            shtqp_pkg::S_CLEAR:
            begin
                // Zero one entry per cycle after reset
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(TABLE_SLOTS - 1))
                begin
                    state_next = shtqp_pkg::S_IDLE;
                end
            end
            shtqp_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd_next  = req.cmd;
                    name_next = req.sym_name[NW-1:0];
                    new_flags_next = '0;
                    new_flags_next[shtqp_pkg::FLAG_REL] = 1'b1;
                    new_flags_next[shtqp_pkg::FLAG_ENT] = req.entry_req;
                    new_flags_next[shtqp_pkg::FLAG_EXT] = req.external_req;
                    state_next = shtqp_pkg::S_HASH;
                end
            end
            shtqp_pkg::S_HASH:
            begin
                rem_next   = hash_val;
                state_next = shtqp_pkg::S_MOD;
            end
            shtqp_pkg::S_MOD:
            begin
                quot_next  = quot_prod[HW +: QW];
                state_next = shtqp_pkg::S_REM;
            end
            shtqp_pkg::S_REM:
            begin
                h_next     = rem_fin;
                d_next     = (AW + 1)'(2);
                full_next  = 1'b0;
                state_next = shtqp_pkg::S_READ;
            end
            shtqp_pkg::S_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = shtqp_pkg::S_CHECK;
            end
            shtqp_pkg::S_CHECK:
            begin
                priority if (full_reg)
                begin
                    res_status_next = shtqp_pkg::STATUS_FULL;
                    res_flags_next  = rd_flags;
                    state_next      = shtqp_pkg::S_DONE;
                end
                else if (slot_empty)
                begin
                    if (cmd_reg == shtqp_pkg::CMD_ADD)
                    begin
                        ram_wr_en       = 1'b1;
                        res_status_next = shtqp_pkg::STATUS_INSERTED;
                        res_flags_next  = new_flags_reg;
                    end
                    else
                    begin
                        res_status_next = shtqp_pkg::STATUS_ABSENT;
                        res_flags_next  = rd_flags;
                    end
                    state_next = shtqp_pkg::S_DONE;
                end
                else if (slot_match)
                begin
                    res_status_next = shtqp_pkg::STATUS_FOUND;
                    res_flags_next  = rd_flags;
                    state_next      = shtqp_pkg::S_DONE;
                end
                else
                begin
                    // Collision: advance by the growing step, give up once the
                    // step reaches the table size
                    h_next     = h_wrap;
                    d_next     = d_inc;
                    full_next  = (d_inc >= (AW + 1)'(TABLE_SLOTS));
                    state_next = shtqp_pkg::S_READ;
                end
            end
            shtqp_pkg::S_DONE:
            begin
                // Load the response once the output register is free
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.status     = res_status_reg;
                    out_data_next.slot_index = h_wide[shtqp_pkg::SLOT_BITS-1:0];
                    out_data_next.slot_flags = res_flags_reg;
                    state_next               = shtqp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = shtqp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shtqp_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        name_reg       <= name_next;
        new_flags_reg  <= new_flags_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        h_reg          <= h_next;
        d_reg          <= d_next;
        full_reg       <= full_next;
        res_status_reg <= res_status_next;
        res_flags_reg  <= res_flags_next;
        out_data_reg   <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

@@ src/shtqp_checker.sv @@
// ----------------------------------------------------------------------------
// Symbol hash table port checker
// Watches the top-level ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
`include "symbol_hash_table_quadratic_probe_assert.svh"

module shtqp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input shtqp_pkg::rsp_t rsp
);

    logic req_take;
    logic rsp_wait;
    logic rel_needed;
    logic rel_ok;

    assign req_take   = req_valid && !req_stall;
    assign rsp_wait   = rsp_valid && rsp_stall;
    assign rel_needed = rsp_valid && (rsp.status == shtqp_pkg::STATUS_FOUND
                                   || rsp.status == shtqp_pkg::STATUS_INSERTED);
    assign rel_ok     = rsp.slot_flags[shtqp_pkg::FLAG_REL];

    // A stalled response holds its payload
    `SHTQP_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp), "stalled response changed")

    // Found and inserted slots always carry the relocatable flag
    `SHTQP_ASSERT(a_rel_flag, !rel_needed || rel_ok, "found or inserted slot lacks relocatable flag")

    // One request at a time: after a transaction is taken the input stalls
    `SHTQP_ASSERT_NEXT(a_one_at_a_time, req_take, req_stall, "request accepted back to back")

endmodule

bind symbol_hash_table_quadratic_probe shtqp_checker u_checker (.*);
